// ===== rtl/kdht_pkg.sv =====
// ----------------------------------------------------------------------------
// kdht_pkg
// Shared types, constants and helpers for the keypad debounce/hold tracker.
// ----------------------------------------------------------------------------
package kdht_pkg;

  localparam int NUM_KEYS  = 16;
  localparam int KEY_IDX_W = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CODE_W    = 3;
  localparam int CNT_W     = 5;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;

  // state codes as reported on the result channel
  localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_DOWN    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_PRESSED = 3'd2;
  localparam logic [CODE_W-1:0] CODE_HELD    = 3'd3;
  localparam logic [CODE_W-1:0] CODE_UP      = 3'd4;

  typedef enum logic [4:0] {
    KS_IDLE    = 5'b00001,
    KS_DOWN    = 5'b00010,
    KS_PRESSED = 5'b00100,
    KS_HELD    = 5'b01000,
    KS_UP      = 5'b10000
  } key_state_t;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] idx;
    logic                 pressed;
    logic [TIME_W-1:0]    now;
    logic                 scan_end;
  } sample_t;

  typedef struct packed {
    logic       hit;
    key_state_t next;
    logic       stamp;
    logic       changed;
  } key_update_t;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key_id;
    logic [CODE_W-1:0]    new_state;
    logic                 state_changed;
    logic                 pass_activity;
    logic [CNT_W-1:0]     active_keys;
  } result_t;

  function automatic logic [CODE_W-1:0] state_code(key_state_t s);
    logic [CODE_W-1:0] c;
    case (s)
      KS_IDLE:    c = CODE_IDLE;
      KS_DOWN:    c = CODE_DOWN;
      KS_PRESSED: c = CODE_PRESSED;
      KS_HELD:    c = CODE_HELD;
      KS_UP:      c = CODE_UP;
      default:    c = CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic is_active(key_state_t s);
    return (s == KS_DOWN) || (s == KS_PRESSED) || (s == KS_HELD);
  endfunction

endpackage

// ===== rtl/kdht_if.sv =====
// ----------------------------------------------------------------------------
// kdht channel interfaces
// Valid/ready channels for key samples in and key results out.
// ----------------------------------------------------------------------------
interface key_sample_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_index;
  logic       key_pressed;
  logic [31:0] now_ms;
  logic       scan_end;

  modport source (output valid, key_index, key_pressed, now_ms, scan_end, input ready);
  modport sink   (input valid, key_index, key_pressed, now_ms, scan_end, output ready);
endinterface

interface key_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_id;
  logic [2:0] new_state;
  logic       state_changed;
  logic       pass_activity;
  logic [4:0] active_keys;

  modport source (output valid, key_id, new_state, state_changed, pass_activity,
                  active_keys, input ready);
  modport sink   (input valid, key_id, new_state, state_changed, pass_activity,
                  active_keys, output ready);
endinterface

// ===== rtl/kdht_key_step.sv =====
// ----------------------------------------------------------------------------
// kdht_key_step
// Per-key transition logic: elapsed-time compares and the five-state step.
// ----------------------------------------------------------------------------
module kdht_key_step
  import kdht_pkg::*;
(
  input  key_state_t        cur_state,
  input  logic [TIME_W-1:0] cur_time,
  input  logic              hit,
  input  sample_t           smp,
  input  logic [CFG_W-1:0]  debounce,
  input  logic [CFG_W-1:0]  hold,
  output key_update_t       upd
);

  logic [TIME_W-1:0] elapsed;
  logic              over_deb;
  logic              under_deb;
  logic              over_hold;
  key_state_t        next;
  logic              stamp;

  // wrapping difference, so a timer rollover is harmless
  assign elapsed   = smp.now - cur_time;
  assign over_deb  = elapsed > TIME_W'(debounce);
  assign under_deb = elapsed < TIME_W'(debounce);
  assign over_hold = elapsed > TIME_W'(hold);

  always_comb begin
    next  = cur_state;
    stamp = 1'b0;
    if (smp.pressed) begin
      case (cur_state)
        KS_IDLE: begin
          next  = KS_DOWN;
          stamp = 1'b1;
        end
        KS_DOWN: next = KS_PRESSED;
        KS_PRESSED: begin
          if (over_hold) begin
            next  = KS_HELD;
            stamp = 1'b1;
          end
        end
        KS_UP: begin
          if (over_deb) begin
            next  = KS_DOWN;
            stamp = 1'b1;
          end
        end
        default: next = cur_state;
      endcase
    end else begin
      case (cur_state)
        KS_DOWN: begin
          if (over_deb) begin
            next  = KS_UP;
            stamp = 1'b1;
          end
        end
        KS_PRESSED: begin
          if (!under_deb) begin
            next  = KS_UP;
            stamp = 1'b1;
          end
        end
        KS_HELD: begin
          next  = KS_UP;
          stamp = 1'b1;
        end
        KS_UP:   next = KS_IDLE;
        default: next = cur_state;
      endcase
    end
  end

  assign upd.hit     = hit;
  assign upd.next    = next;
  assign upd.stamp   = hit && stamp;
  assign upd.changed = hit && (next != cur_state);

endmodule

// ===== rtl/kdht_key_table.sv =====
// ----------------------------------------------------------------------------
// kdht_key_table
// Per-key state and timestamp bank, running active-key count and pass flag.
// ----------------------------------------------------------------------------
module kdht_key_table
  import kdht_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sample_t           smp,
  input  key_update_t       upd,
  output logic              hit,
  output key_state_t        cur_state,
  output logic [TIME_W-1:0] cur_time,
  output logic              pass_activity,
  output logic [CNT_W-1:0]  active_next
);

  key_state_t        key_state [NUM_KEYS];
  logic [TIME_W-1:0] key_time  [NUM_KEYS];
  logic              pass_flag;
  logic [CNT_W-1:0]  active_count;
  logic              flag_merge;
  logic              was_active;
  logic              now_active;

  assign hit       = {1'b0, smp.idx} < (KEY_IDX_W+1)'(NUM_KEYS);
  assign cur_state = hit ? key_state[smp.idx] : KS_IDLE;
  assign cur_time  = hit ? key_time[smp.idx] : '0;

  // only the sampled key can move, so the count tracks by +1/-1
  assign was_active = hit && is_active(cur_state);
  assign now_active = hit && is_active(upd.next);

  always_comb begin
    active_next = active_count;
    if (now_active && !was_active) begin
      active_next = active_count + CNT_W'(1);
    end else if (was_active && !now_active) begin
      active_next = active_count - CNT_W'(1);
    end
  end

  assign flag_merge    = pass_flag | upd.changed;
  assign pass_activity = smp.scan_end & flag_merge;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_state[i] <= KS_IDLE;
        key_time[i]  <= '0;
      end
      pass_flag    <= 1'b0;
      active_count <= '0;
    end else if (fire) begin
      if (upd.hit) begin
        key_state[smp.idx] <= upd.next;
      end
      if (upd.stamp) begin
        key_time[smp.idx] <= smp.now;
      end
      pass_flag    <= smp.scan_end ? 1'b0 : flag_merge;
      active_count <= active_next;
    end
  end

endmodule

// ===== rtl/keypad_debounce_hold_tracker.sv =====
// ----------------------------------------------------------------------------
// keypad_debounce_hold_tracker
// Debounce and hold tracking for a scanned keypad matrix, one key per request.
// ----------------------------------------------------------------------------
// One key sample is taken per request and gives one result. The block takes a
// new request every cycle while the result side is not stalled; each result
// passes the input register, then the result register. The rate is set by
// the read-modify-write of the per-key state and timestamp registers between
// those two stages, so a sample for the same key may follow in the very next
// cycle. Registers are written through cfg_we/cfg_index/cfg_data and should
// only change while idle.
module keypad_debounce_hold_tracker
  import kdht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  key_sample_if.sink           samples,
  key_result_if.source         results
);

  logic              s1_valid;
  sample_t           s1;
  logic              s2_valid;
  result_t           s2;
  logic              s1_advance;
  logic [CFG_W-1:0]  debounce;
  logic [CFG_W-1:0]  hold;
  logic              hit;
  key_state_t        cur_state;
  logic [TIME_W-1:0] cur_time;
  key_update_t       upd;
  logic              pass_activity;
  logic [CNT_W-1:0]  active_next;
  result_t           result;

  assign s1_advance    = s1_valid && (!s2_valid || results.ready);
  assign samples.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      debounce <= DEBOUNCE_RESET;
      hold     <= HOLD_RESET;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end
      if (s1_advance) begin
        s2_valid <= 1'b1;
      end else if (results.ready) begin
        s2_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce <= cfg_data;
          REG_HOLD:     hold     <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1.idx      <= samples.key_index;
      s1.pressed  <= samples.key_pressed;
      s1.now      <= samples.now_ms;
      s1.scan_end <= samples.scan_end;
    end
    if (s1_advance) begin
      s2 <= result;
    end
  end

  kdht_key_table u_table (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_advance),
    .smp           (s1),
    .upd           (upd),
    .hit           (hit),
    .cur_state     (cur_state),
    .cur_time      (cur_time),
    .pass_activity (pass_activity),
    .active_next   (active_next)
  );

  kdht_key_step u_step (
    .cur_state (cur_state),
    .cur_time  (cur_time),
    .hit       (hit),
    .smp       (s1),
    .debounce  (debounce),
    .hold      (hold),
    .upd       (upd)
  );

  always_comb begin
    result.key_id        = s1.idx;
    result.new_state     = hit ? state_code(upd.next) : CODE_IDLE;
    result.state_changed = upd.changed;
    result.pass_activity = pass_activity;
    result.active_keys   = active_next;
  end

  assign results.valid         = s2_valid;
  assign results.key_id        = s2.key_id;
  assign results.new_state     = s2.new_state;
  assign results.state_changed = s2.state_changed;
  assign results.pass_activity = s2.pass_activity;
  assign results.active_keys   = s2.active_keys;

endmodule

// ===== rtl/kdht_checker.sv =====
// ----------------------------------------------------------------------------
// kdht_checker
// Port-level checks for the keypad debounce/hold tracker, bound to the top.
// ----------------------------------------------------------------------------
module kdht_checker
  import kdht_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KEY_IDX_W-1:0] out_key_id,
  input logic [CODE_W-1:0]    out_new_state,
  input logic                 out_state_changed,
  input logic                 out_pass_activity,
  input logic [CNT_W-1:0]     out_active_keys
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key_id) &&
      $stable(out_new_state) && $stable(out_state_changed) &&
      $stable(out_pass_activity) && $stable(out_active_keys))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

  // requests are only refused while a result is pending and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without result-side stall");

  // the running count never exceeds the key count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_active_keys <= CNT_W'(NUM_KEYS))
    else $error("active key count out of range");

endmodule

bind keypad_debounce_hold_tracker kdht_checker u_kdht_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (samples.ready),
  .out_valid         (results.valid),
  .out_ready         (results.ready),
  .out_key_id        (results.key_id),
  .out_new_state     (results.new_state),
  .out_state_changed (results.state_changed),
  .out_pass_activity (results.pass_activity),
  .out_active_keys   (results.active_keys)
);
